>>> rtl/lru_page_frame_manager_macros.svh
// assertion macros shared by the page frame manager rtl
// no dependencies, included by the files that carry assertions
`ifndef LRU_PAGE_FRAME_MANAGER_MACROS_SVH
`define LRU_PAGE_FRAME_MANAGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPFM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lpfm_pkg.sv
// package for the page frame manager: sizes, action codes and transaction types
// no dependencies, used by every module of the block
package lpfm_pkg;

  localparam int NUM_FRAMES        = 64;
  localparam int NUM_PROCESSES     = 16;
  localparam int PAGES_PER_PROCESS = 64;

  // internal widths follow the table sizes
  localparam int FRAME_W = $clog2(NUM_FRAMES);
  localparam int SLOT_W  = $clog2(NUM_PROCESSES);
  localparam int PAGE_W  = $clog2(PAGES_PER_PROCESS);
  localparam int CNT_W   = $clog2(NUM_FRAMES + 1);

  // fixed field widths of the channels
  localparam int IN_SLOT_W   = 4;
  localparam int IN_PAGE_W   = 6;
  localparam int STAMP_W     = 16;
  localparam int OUT_FRAME_W = 6;
  localparam int ACT_W       = 2;
  localparam int LIMIT_W     = 7;
  localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

  // action codes
  localparam logic [ACT_W-1:0] ACT_HIT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GLOBAL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_OWN    = 2'd3;

  typedef struct packed {
    logic [IN_SLOT_W-1:0] process_slot;
    logic [IN_PAGE_W-1:0] page_number;
    logic [STAMP_W-1:0]   timestamp;
  } lpfm_in_t;

  typedef struct packed {
    logic [OUT_FRAME_W-1:0] frame_index;
    logic [ACT_W-1:0]       action;
    logic                   evicted_valid;
    logic [IN_SLOT_W-1:0]   evicted_slot;
    logic [IN_PAGE_W-1:0]   evicted_page;
  } lpfm_out_t;

  // one frame table entry
  typedef struct packed {
    logic [SLOT_W-1:0]  owner;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } lpfm_entry_t;

  // summary of one pass over the frame table
  typedef struct packed {
    logic               hit_found;
    logic [FRAME_W-1:0] hit_idx;
    logic [CNT_W-1:0]   own_cnt;
    logic               own_found;
    logic [FRAME_W-1:0] own_idx;
    logic [PAGE_W-1:0]  own_page;
    logic               free_found;
    logic [FRAME_W-1:0] free_idx;
    logic               glob_found;
    logic [FRAME_W-1:0] glob_idx;
    logic [SLOT_W-1:0]  glob_owner;
    logic [PAGE_W-1:0]  glob_page;
  } lpfm_scan_res_t;

endpackage

>>> rtl/lpfm_frame_table.sv
// frame table: owner, page and stamp memory plus the per-frame used bits
// depends on lpfm_pkg
module lpfm_frame_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [lpfm_pkg::FRAME_W-1:0]  rd_addr,
  output lpfm_pkg::lpfm_entry_t         rd_entry,
  output logic                          rd_used,
  input  logic                          wr_en,
  input  logic [lpfm_pkg::FRAME_W-1:0]  wr_addr,
  input  lpfm_pkg::lpfm_entry_t         wr_entry
);

  lpfm_pkg::lpfm_entry_t               mem [lpfm_pkg::NUM_FRAMES];
  logic [lpfm_pkg::NUM_FRAMES-1:0]     used_r;
  lpfm_pkg::lpfm_entry_t               rd_entry_r;
  logic                                rd_used_r;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
      rd_used_r  <= used_r[rd_addr];
    end
  end

  // used bits, all frames free after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_en) begin
      used_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_used  = rd_used_r;

endmodule

>>> rtl/lpfm_scan.sv
// scan unit: takes one frame entry a cycle and tracks hit, free and oldest frames
// depends on lpfm_pkg
module lpfm_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          step_valid,
  input  logic [lpfm_pkg::FRAME_W-1:0]  step_idx,
  input  lpfm_pkg::lpfm_entry_t         entry,
  input  logic                          used,
  input  logic [lpfm_pkg::SLOT_W-1:0]   slot,
  input  logic [lpfm_pkg::PAGE_W-1:0]   page,
  output lpfm_pkg::lpfm_scan_res_t      res
);

  logic                           hit_found_r;
  logic [lpfm_pkg::FRAME_W-1:0]   hit_idx_r;
  logic [lpfm_pkg::CNT_W-1:0]     own_cnt_r;
  logic                           own_found_r;
  logic [lpfm_pkg::FRAME_W-1:0]   own_idx_r;
  logic [lpfm_pkg::PAGE_W-1:0]    own_page_r;
  logic [lpfm_pkg::STAMP_W-1:0]   own_stamp_r;
  logic                           free_found_r;
  logic [lpfm_pkg::FRAME_W-1:0]   free_idx_r;
  logic                           glob_found_r;
  logic [lpfm_pkg::FRAME_W-1:0]   glob_idx_r;
  logic [lpfm_pkg::SLOT_W-1:0]    glob_owner_r;
  logic [lpfm_pkg::PAGE_W-1:0]    glob_page_r;
  logic [lpfm_pkg::STAMP_W-1:0]   glob_stamp_r;

  logic owned;
  logic is_hit;
  logic own_better;
  logic glob_better;

  // compare the current entry against the running bests, strict less keeps lowest index
  always_comb begin
    owned       = used && (entry.owner == slot);
    is_hit      = owned && (entry.page == page);
    own_better  = owned && (!own_found_r || (entry.stamp < own_stamp_r));
    glob_better = used && (!glob_found_r || (entry.stamp < glob_stamp_r));
  end

  // flags and count are control state
  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      hit_found_r  <= 1'b0;
      own_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      glob_found_r <= 1'b0;
      own_cnt_r    <= '0;
    end else if (step_valid) begin
      if (is_hit) begin
        hit_found_r <= 1'b1;
      end
      if (owned) begin
        own_cnt_r <= own_cnt_r + lpfm_pkg::CNT_W'(1);
      end
      if (own_better) begin
        own_found_r <= 1'b1;
      end
      if (!used) begin
        free_found_r <= 1'b1;
      end
      if (glob_better) begin
        glob_found_r <= 1'b1;
      end
    end
  end

  // tracked indexes and stamps
  always_ff @(posedge clk) begin
    if (step_valid && !start) begin
      if (is_hit) begin
        hit_idx_r <= step_idx;
      end
      if (own_better) begin
        own_idx_r   <= step_idx;
        own_page_r  <= entry.page;
        own_stamp_r <= entry.stamp;
      end
      if (!used && !free_found_r) begin
        free_idx_r <= step_idx;
      end
      if (glob_better) begin
        glob_idx_r   <= step_idx;
        glob_owner_r <= entry.owner;
        glob_page_r  <= entry.page;
        glob_stamp_r <= entry.stamp;
      end
    end
  end

  always_comb begin
    res.hit_found  = hit_found_r;
    res.hit_idx    = hit_idx_r;
    res.own_cnt    = own_cnt_r;
    res.own_found  = own_found_r;
    res.own_idx    = own_idx_r;
    res.own_page   = own_page_r;
    res.free_found = free_found_r;
    res.free_idx   = free_idx_r;
    res.glob_found = glob_found_r;
    res.glob_idx   = glob_idx_r;
    res.glob_owner = glob_owner_r;
    res.glob_page  = glob_page_r;
  end

endmodule

>>> rtl/lru_page_frame_manager.sv
// top level of the page frame manager: sequencer, config register and result register
// depends on lpfm_pkg, lpfm_frame_table, lpfm_scan and the assertion macro header
//
// Usage:
// - in channel (in_valid/in_ready/in_data) takes one page access transaction:
//   process slot, page number and timestamp.
// - out channel (out_valid/out_ready/out_data) returns exactly one result per
//   access: frame index, action, and the evicted slot and page if any.
// - cfg channel (cfg_valid/cfg_ready/cfg_data) writes the working set limit;
//   always ready, to be written only while no access is in flight.
// - each access walks the whole frame table through its single read port, one
//   frame a cycle, then passes a drain state and a decide and update state.
// - the result goes to the output register from the done state; a new access is
//   taken only once the block is back in idle, after that hand-over.
// - the result register lets the next access start while a result still waits;
//   a stalled receiver only holds the block when a second result is finished.
// - reset (synchronous, active low) frees every frame, empties all working
//   sets and sets the limit to 4. No clearing pass is needed.
`include "lru_page_frame_manager_macros.svh"

module lru_page_frame_manager (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lpfm_pkg::lpfm_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lpfm_pkg::lpfm_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lpfm_pkg::LIMIT_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [lpfm_pkg::FRAME_W-1:0] LAST_FRAME =
    lpfm_pkg::FRAME_W'(lpfm_pkg::NUM_FRAMES - 1);

  logic [2:0]                        state_r, state_nxt;
  logic [lpfm_pkg::LIMIT_W-1:0]      limit_r;
  lpfm_pkg::lpfm_entry_t             req_r;
  logic [lpfm_pkg::FRAME_W-1:0]      addr_r;
  logic                              step_valid_r;
  logic [lpfm_pkg::FRAME_W-1:0]      step_idx_r;
  lpfm_pkg::lpfm_out_t               res_r, res_nxt;
  logic                              out_valid_r;
  lpfm_pkg::lpfm_out_t               out_data_r;

  logic                              in_fire;
  logic                              out_free;
  logic                              rd_en;
  lpfm_pkg::lpfm_entry_t             rd_entry;
  logic                              rd_used;
  logic                              wr_en;
  logic [lpfm_pkg::FRAME_W-1:0]      frame_sel;
  lpfm_pkg::lpfm_scan_res_t          scan_res;
  logic                              own_take;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign rd_en     = (state_r == ST_SCAN);
  assign wr_en     = (state_r == ST_DECIDE);

  // working set limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lpfm_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r == LAST_FRAME) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_valid_r <= rd_en;
    end
  end

  // request capture, slot and page reduced to the table sizes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r.owner <= in_data.process_slot[lpfm_pkg::SLOT_W-1:0];
      req_r.page  <= in_data.page_number[lpfm_pkg::PAGE_W-1:0];
      req_r.stamp <= in_data.timestamp;
    end
  end

  // scan address and the index of the entry arriving from the table
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r <= '0;
    end else if (rd_en) begin
      addr_r <= addr_r + lpfm_pkg::FRAME_W'(1);
    end
    step_idx_r <= addr_r;
  end

  lpfm_frame_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (addr_r),
    .rd_entry (rd_entry),
    .rd_used  (rd_used),
    .wr_en    (wr_en),
    .wr_addr  (frame_sel),
    .wr_entry (req_r)
  );

  lpfm_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .step_valid (step_valid_r),
    .step_idx   (step_idx_r),
    .entry      (rd_entry),
    .used       (rd_used),
    .slot       (req_r.owner),
    .page       (req_r.page),
    .res        (scan_res)
  );

  // replacement decision from the scan summary
  always_comb begin
    own_take = (lpfm_pkg::CMP_W'(scan_res.own_cnt) >= lpfm_pkg::CMP_W'(limit_r)) &&
               scan_res.own_found;
    frame_sel             = '0;
    res_nxt.action        = lpfm_pkg::ACT_HIT;
    res_nxt.evicted_valid = 1'b0;
    res_nxt.evicted_slot  = '0;
    res_nxt.evicted_page  = '0;
    if (scan_res.hit_found) begin
      frame_sel = scan_res.hit_idx;
    end else if (own_take) begin
      frame_sel             = scan_res.own_idx;
      res_nxt.action        = lpfm_pkg::ACT_OWN;
      res_nxt.evicted_valid = 1'b1;
      res_nxt.evicted_slot  = lpfm_pkg::IN_SLOT_W'(req_r.owner);
      res_nxt.evicted_page  = lpfm_pkg::IN_PAGE_W'(scan_res.own_page);
    end else if (scan_res.free_found) begin
      frame_sel      = scan_res.free_idx;
      res_nxt.action = lpfm_pkg::ACT_FREE;
    end else begin
      res_nxt.action = lpfm_pkg::ACT_GLOBAL;
      if (scan_res.glob_found) begin
        frame_sel             = scan_res.glob_idx;
        res_nxt.evicted_valid = 1'b1;
        res_nxt.evicted_slot  = lpfm_pkg::IN_SLOT_W'(scan_res.glob_owner);
        res_nxt.evicted_page  = lpfm_pkg::IN_PAGE_W'(scan_res.glob_page);
      end
    end
    res_nxt.frame_index = lpfm_pkg::OUT_FRAME_W'(frame_sel);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      res_r <= res_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `LPFM_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_valid && in_ready, state_r == ST_SCAN && addr_r == '0, "accepted access did not start a scan")
  `LPFM_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid && out_data.action == lpfm_pkg::ACT_HIT, !out_data.evicted_valid, "hit reported an eviction")
  `LPFM_ASSERT_NOW(a_free_no_evict, clk, rst_n, out_valid && out_data.action == lpfm_pkg::ACT_FREE, !out_data.evicted_valid, "free allocation reported an eviction")
  `LPFM_ASSERT_NOW(a_replace_evicts, clk, rst_n, out_valid && (out_data.action == lpfm_pkg::ACT_OWN || out_data.action == lpfm_pkg::ACT_GLOBAL), out_data.evicted_valid, "replacement without eviction")
  `LPFM_ASSERT_NEXT(a_scan_feeds_unit, clk, rst_n, state_r == ST_SCAN, step_valid_r && step_idx_r == $past(addr_r), "scan unit missed a frame")

endmodule

>>> tb/sv/lru_page_frame_manager_checker.sv
// checker for the page frame manager: watches the three channels, predicts each result
// depends on lpfm_pkg; instantiated beside the block by lru_page_frame_manager_tb
`timescale 1ns / 100ps

module lru_page_frame_manager_checker
  import lpfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  lpfm_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  lpfm_out_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int MAP_SIZE = NUM_PROCESSES * PAGES_PER_PROCESS;

  // shadow copy of the frame table, page maps and working sets
  logic [SLOT_W-1:0]  owner_tbl [NUM_FRAMES];
  logic [PAGE_W-1:0]  page_tbl  [NUM_FRAMES];
  logic [STAMP_W-1:0] stamp_tbl [NUM_FRAMES];
  bit                 used_tbl  [NUM_FRAMES];
  bit                 map_ok    [MAP_SIZE];
  int                 map_at    [MAP_SIZE];
  int                 held      [NUM_PROCESSES];
  logic [LIMIT_W-1:0] limit_q;

  lpfm_out_t predicted_frames [$];
  int        fail_total;

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_total++;
  endtask

  // least recently stamped used frame, lowest index on a tie; NUM_FRAMES if none
  function automatic int oldest_frame(input bit mine_only, input int who);
    int best;
    best = NUM_FRAMES;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (used_tbl[i] && (!mine_only || int'(owner_tbl[i]) == who)) begin
        if (best == NUM_FRAMES || stamp_tbl[i] < stamp_tbl[best]) best = i;
      end
    end
    return best;
  endfunction

  // one page access against the shadow tables
  function automatic lpfm_out_t resolve_access(input lpfm_in_t acc);
    lpfm_out_t res;
    int slot, page, key, frame, own, os, op;
    slot  = int'(acc.process_slot) % NUM_PROCESSES;
    page  = int'(acc.page_number) % PAGES_PER_PROCESS;
    key   = slot * PAGES_PER_PROCESS + page;
    frame = 0;
    res   = '0;
    if (map_ok[key] && map_at[key] < NUM_FRAMES) begin
      // hit: restamp only
      frame = map_at[key];
      stamp_tbl[frame] = acc.timestamp;
      res.action = ACT_HIT;
    end else begin
      own = NUM_FRAMES;
      if (held[slot] >= int'(limit_q)) own = oldest_frame(1'b1, slot);
      if (own < NUM_FRAMES) begin
        frame = own;
        res.action = ACT_OWN;
      end else begin
        frame = NUM_FRAMES;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
          if (!used_tbl[i]) frame = i;
        end
        if (frame < NUM_FRAMES) begin
          res.action = ACT_FREE;
        end else begin
          frame = oldest_frame(1'b0, 0);
          if (frame >= NUM_FRAMES) frame = 0;
          res.action = ACT_GLOBAL;
        end
      end
      // evict whatever lived in the chosen frame
      if (used_tbl[frame]) begin
        os = int'(owner_tbl[frame]) % NUM_PROCESSES;
        op = int'(page_tbl[frame]) % PAGES_PER_PROCESS;
        map_ok[os * PAGES_PER_PROCESS + op] = 1'b0;
        if (held[os] > 0) held[os]--;
        res.evicted_valid = 1'b1;
        res.evicted_slot  = IN_SLOT_W'(os);
        res.evicted_page  = IN_PAGE_W'(op);
      end
      used_tbl[frame]  = 1'b1;
      owner_tbl[frame] = SLOT_W'(slot);
      page_tbl[frame]  = PAGE_W'(page);
      stamp_tbl[frame] = acc.timestamp;
      map_ok[key]      = 1'b1;
      map_at[key]      = frame;
      held[slot]++;
    end
    res.frame_index = OUT_FRAME_W'(frame);
    return res;
  endfunction

  // sample every channel at the rising edge
  always @(posedge clk) begin : monitor
    lpfm_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        owner_tbl[i] = '0;
        page_tbl[i]  = '0;
        stamp_tbl[i] = '0;
        used_tbl[i]  = 1'b0;
      end
      for (int k = 0; k < MAP_SIZE; k++) begin
        map_ok[k] = 1'b0;
        map_at[k] = 0;
      end
      for (int s = 0; s < NUM_PROCESSES; s++) held[s] = 0;
      limit_q = LIMIT_RESET;
      predicted_frames.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_q = cfg_data;
      if (in_valid && in_ready) predicted_frames.push_back(resolve_access(in_data));
      if (out_valid && out_ready) begin
        if (predicted_frames.size() == 0) begin
          flag_mismatch("result with no access pending", int'(out_data), 0);
        end else begin
          want = predicted_frames.pop_front();
          if (out_data.frame_index !== want.frame_index)
            flag_mismatch("frame_index", int'(out_data.frame_index),
                          int'(want.frame_index));
          if (out_data.action !== want.action)
            flag_mismatch("action", int'(out_data.action), int'(want.action));
          if (out_data.evicted_valid !== want.evicted_valid)
            flag_mismatch("evicted_valid", int'(out_data.evicted_valid),
                          int'(want.evicted_valid));
          if (out_data.evicted_slot !== want.evicted_slot)
            flag_mismatch("evicted_slot", int'(out_data.evicted_slot),
                          int'(want.evicted_slot));
          if (out_data.evicted_page !== want.evicted_page)
            flag_mismatch("evicted_page", int'(out_data.evicted_page),
                          int'(want.evicted_page));
        end
      end
    end
    outstanding <= predicted_frames.size();
    mismatches  <= fail_total;
  end

endmodule

>>> tb/sv/lru_page_frame_manager_tb.sv
// top of the page frame manager testbench: clock, reset, stimulus and verdict
// depends on lpfm_pkg, lru_page_frame_manager and lru_page_frame_manager_checker
`timescale 1ns / 100ps

module lru_page_frame_manager_tb;
  import lpfm_pkg::*;

  localparam int HANG_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 60;
  localparam int NUM_PHASES   = 8;
  localparam int SETTLE_TICKS = 80;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  lpfm_in_t           in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lpfm_out_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  int                 mismatches;
  int                 outstanding;
  bit                 quiet_run = 1'b0;
  int                 ready_left = 0;
  logic [STAMP_W-1:0] stamp_now = '0;

  // limits visited by the random phases, extremes included
  logic [LIMIT_W-1:0] phase_limit [NUM_PHASES] = '{7'd64, 7'd1, 7'd127, 7'd8,
                                                   7'd0, 7'd16, 7'd3, 7'd4};

  lru_page_frame_manager u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lru_page_frame_manager_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver back-pressure in bursts, each stall followed by a ready stretch,
  // none in the final phase
  always @(negedge clk) begin
    if (quiet_run) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_ready && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_left = $urandom_range(0, 17);
    end else begin
      out_ready  <= 1'b1;
      ready_left = $urandom_range(0, 39);
    end
  end

  function automatic lpfm_in_t access(input int slot, input int page, input int stamp);
    lpfm_in_t a;
    a.process_slot = IN_SLOT_W'(slot);
    a.page_number  = IN_PAGE_W'(page);
    a.timestamp    = STAMP_W'(stamp);
    return a;
  endfunction

  // random access: half from a hot set of slots and pages so hits come often
  function automatic lpfm_in_t make_access();
    lpfm_in_t a;
    stamp_now = stamp_now + STAMP_W'($urandom_range(0, 40));
    if ($urandom_range(0, 1) == 0) begin
      a.process_slot = IN_SLOT_W'($urandom_range(0, 3));
      a.page_number  = IN_PAGE_W'($urandom_range(0, 7));
    end else begin
      a.process_slot = IN_SLOT_W'($urandom_range(0, 15));
      a.page_number  = IN_PAGE_W'($urandom_range(0, 63));
    end
    if ($urandom_range(0, 9) == 0) a.timestamp = STAMP_W'($urandom_range(0, 65535));
    else a.timestamp = stamp_now;
    return a;
  endfunction

  // one access transaction, called and returning at a falling edge
  task automatic send(input lpfm_in_t acc);
    int gap;
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold the sender off until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // limit write, only with the block idle
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hang detection: too long without any transaction
  initial begin : watchdog
    int quiet_ticks;
    quiet_ticks = 0;
    while (quiet_ticks < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_ticks = 0;
      else
        quiet_ticks++;
    end
    $display("** lru_page_frame_manager: FAILED **");
    $finish;
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset limit of four
    send(access(0, 0, 0));          // first free frame
    send(access(0, 0, 65535));      // hit, restamp with top stamp
    send(access(0, 1, 100));        // equal stamps, tie goes to the lowest frame
    send(access(0, 2, 100));
    send(access(0, 3, 100));
    send(access(0, 4, 200));        // at the limit: own-set replace
    send(access(15, 63, 65535));    // top slot and page
    send(access(15, 63, 0));        // hit with zero stamp
    send(access(15, 0, 7));

    // limit lowered below the count already held
    write_limit(7'd2);
    send(access(0, 5, 300));
    send(access(0, 6, 301));
    send(access(0, 4, 302));        // hit after the lowered limit

    // limit zero: a process with no frames still takes the free path
    write_limit(7'd0);
    send(access(1, 0, 400));
    send(access(1, 1, 500));        // then replaces its only frame
    send(access(2, 63, 65535));
    send(access(2, 62, 0));

    // largest limit
    write_limit(7'd127);
    send(access(3, 21, 42));
    send(access(3, 42, 21));
    send(access(3, 21, 43));
    send(access(14, 1, 1));

    // random phases, each at its own limit; the last one without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      if (p == NUM_PHASES - 1) quiet_run = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) drain_results();
        send(make_access());
      end
    end

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0)
      $display("** lru_page_frame_manager: PASSED **");
    else
      $display("** lru_page_frame_manager: FAILED **");
    $finish;
  end

endmodule
